[sv/vgps_pkg.sv]
// ----------------------------------------------------------------------------
// vgps_pkg: shared types and constants of the variance gamma price stepper
// Holds the fixed-point constants, the register index codes, the sequencer
// states and the reciprocal table used for the exponential series.
// ----------------------------------------------------------------------------
`default_nettype none

package vgps_pkg;

  localparam int PRICE_W   = 48;
  localparam int QUO_W     = 15;
  localparam int EXP_TERMS = 13;

  localparam logic [27:0] LN2_Q28     = 28'd186065279;
  localparam logic [28:0] ONE_Q28     = 29'd268435456;
  localparam logic [47:0] PRICE_RESET = 48'd1677721600;
  localparam logic [47:0] PRICE_MAX   = 48'hFFFF_FFFF_FFFF;

  // Bias that makes the exponent non-negative before the division by ln2.
  localparam logic [41:0] DIV_BIAS  = {14'd0, LN2_Q28} << (QUO_W - 1);
  localparam logic [15:0] QUO_BIAS  = 16'd1 << (QUO_W - 1);

  // floor(2^16 / ln2): the quotient estimate from the upper 30 dividend bits
  // is low by at most one.
  localparam logic [16:0] LN2_RECIP = 17'd94548;

  typedef enum logic [2:0] {
    REG_START_PRICE = 3'd0,
    REG_THETA       = 3'd1,
    REG_SIGMA       = 3'd2,
    REG_DRIFT       = 3'd3,
    REG_STEPS       = 3'd4
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TG,
    S_TGW,
    S_SQRT,
    S_SS,
    S_VOL,
    S_E,
    S_DIV,
    S_QUO,
    S_REM,
    S_EXPA,
    S_EXPB,
    S_EXPC,
    S_PA,
    S_PB,
    S_PC,
    S_SHIFT,
    S_FIN
  } state_t;

  // ceil(2^32 / i): floor(x * recip(i) / 2^32) equals floor(x / i) for x < 2^28.
  function automatic logic [32:0] recip(input logic [3:0] i);
    logic [32:0] r;
    case (i)
      4'd1:    r = 33'd4294967296;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655766;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993460;
      4'd6:    r = 33'd715827883;
      4'd7:    r = 33'd613566757;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218589;
      4'd10:   r = 33'd429496730;
      4'd11:   r = 33'd390451573;
      4'd12:   r = 33'd357913942;
      4'd13:   r = 33'd330382100;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/vgps_if.sv]
// ----------------------------------------------------------------------------
// vgps_if: request channels of the variance gamma price stepper
// One interface for incoming variates and one for outgoing price results.
// ----------------------------------------------------------------------------
`default_nettype none

interface vgps_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] gamma_variate;
  logic signed [31:0] normal_variate;
  logic               new_path;

  modport source (output valid, gamma_variate, normal_variate, new_path, input ready);
  modport sink   (input valid, gamma_variate, normal_variate, new_path, output ready);
endinterface

interface vgps_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] price;
  logic [15:0] step_number;
  logic        last_of_path;
  logic        saturated;

  modport source (output valid, price, step_number, last_of_path, saturated, input ready);
  modport sink   (input valid, price, step_number, last_of_path, saturated, output ready);
endinterface

`default_nettype wire

[sv/vgps_mul.sv]
// ----------------------------------------------------------------------------
// vgps_mul: shared registered multiplier
// Signed 34 by 34 bit multiply with the product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vgps_mul (
  input  wire logic               clk,
  input  wire logic signed [33:0] a,
  input  wire logic signed [33:0] b,
  output logic signed      [67:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

[sv/vgps_sqrt.sv]
// ----------------------------------------------------------------------------
// vgps_sqrt: bit-serial integer square root
// Computes floor(sqrt(radicand * 2^32)), one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vgps_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] radicand,
  output logic             done,
  output logic      [31:0] root
);

  logic [63:0] rad;
  logic [33:0] remd;
  logic [4:0]  cnt;
  logic        busy;
  logic [35:0] remd_t;
  logic [35:0] trial;
  logic        take;

  assign remd_t = {remd, rad[63:62]};
  assign trial  = {2'b00, root, 2'b01};
  assign take   = (remd_t >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {radicand, 32'd0};
      remd <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[61:0], 2'b00};
      if (take) begin
        remd <= 34'(remd_t - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        remd <= remd_t[33:0];
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[sv/vgps_div.sv]
// ----------------------------------------------------------------------------
// vgps_div: final step of the division by ln2
// Turns a quotient estimate that is exact or low by one into the exact
// quotient and remainder with a single compare and subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module vgps_div
  import vgps_pkg::*;
(
  input  wire logic [41:0]      dividend,
  input  wire logic [QUO_W-1:0] quo_est,
  input  wire logic [42:0]      quo_prod,
  output logic      [QUO_W-1:0] quo,
  output logic      [27:0]      rem
);

  logic [28:0] part;
  logic        fix;

  // The estimate leaves a remainder below twice ln2.
  assign part = 29'({1'b0, dividend} - quo_prod);
  assign fix  = (part >= {1'b0, LN2_Q28});
  assign quo  = fix ? quo_est + QUO_W'(1) : quo_est;
  assign rem  = fix ? 28'(part - {1'b0, LN2_Q28}) : part[27:0];

endmodule

`default_nettype wire

[sv/variance_gamma_price_step.sv]
// ----------------------------------------------------------------------------
// variance_gamma_price_step: one time step of a variance gamma price path
// Sequencer around a shared multiplier, a square root unit and an ln2 reduction.
// ----------------------------------------------------------------------------
// Each accepted request advances the path price by exp(drift + theta*g +
// sigma*sqrt(g)*z) in Q24.24 fixed point and returns one result. The bit-serial
// square root starts at acceptance, the exponent is then reduced by ln2
// through a reciprocal multiply and one correction, the 13-term exponential
// series runs on the shared multiplier and ten single multiply, latch and
// shift steps make up the rest. The block takes one item at a time; a
// finished result waits in an output register while the next item is
// accepted, and the block holds its last step until that register is free.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module variance_gamma_price_step
  import vgps_pkg::*;
#(
  parameter int STEP_COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [47:0] cfg_wdata,
  vgps_in_if.sink          variates,
  vgps_out_if.source       results
);

  localparam int CmpW = (STEP_COUNT_BITS > 16) ? STEP_COUNT_BITS : 16;

  state_t state, state_next;

  logic        [47:0] start_price;
  logic signed [31:0] theta;
  logic        [30:0] sigma;
  logic signed [31:0] drift_per_step;
  logic        [15:0] steps_per_path;

  logic [47:0]                current_price;
  logic [STEP_COUNT_BITS-1:0] step_count;

  logic        [31:0] g;
  logic signed [31:0] z;
  logic signed [39:0] tg;
  logic        [41:0] dvd;
  logic [QUO_W-1:0]   quo_est;
  logic signed [15:0] n;
  logic        [27:0] r;
  logic        [28:0] term;
  logic        [29:0] sum;
  logic        [3:0]  idx;
  logic        [53:0] pa;
  logic        [50:0] m;
  logic        [47:0] res_price;
  logic               res_sat;
  logic        [15:0] res_step;
  logic               res_last;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic               sqrt_start, sqrt_done;
  logic        [31:0] root;
  logic [QUO_W-1:0]   quo;
  logic        [27:0] div_rem;

  logic                       accept;
  logic                       restart;
  logic [STEP_COUNT_BITS-1:0] cnt_new;
  logic [CmpW-1:0]            cnt_ext, steps_ext, cnt_new_ext;
  logic signed [41:0]         e_sum;
  logic        [41:0]         dvd_sum;
  logic        [28:0]         term_new;
  logic        [54:0]         low_sum;
  logic        [98:0]         shl;
  logic        [50:0]         shr;
  logic        [15:0]         amt;
  logic        [47:0]         price_calc;
  logic                       sat_calc;
  logic                       out_free;

  vgps_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  vgps_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(variates.gamma_variate),
    .done(sqrt_done), .root(root)
  );

  vgps_div u_div (
    .dividend(dvd), .quo_est(quo_est), .quo_prod(prod[42:0]),
    .quo(quo), .rem(div_rem)
  );

  assign accept    = variates.valid && variates.ready;
  assign out_free  = !results.valid || results.ready;
  assign cnt_ext   = CmpW'(step_count);
  assign steps_ext = CmpW'(steps_per_path);
  assign restart   = variates.new_path || (cnt_ext >= steps_ext);
  assign cnt_new   = restart ? STEP_COUNT_BITS'(1) : step_count + STEP_COUNT_BITS'(1);
  assign cnt_new_ext = CmpW'(cnt_new);

  assign e_sum    = 42'(drift_per_step) + 42'(tg) + 42'($signed(prod[62:24]));
  assign dvd_sum  = 42'(e_sum + $signed(DIV_BIAS));
  assign term_new = prod[60:32];
  assign low_sum  = 55'({pa[3:0], 24'd0}) + 55'(prod[53:0]);

  // Scale the mantissa by 2^n with saturation on overflow.
  assign shl = {48'd0, m} << n[5:0];
  assign amt = 16'(-n);
  assign shr = m >> amt[5:0];

  always_comb begin
    price_calc = '0;
    sat_calc   = 1'b0;
    if (n > 16'sd0) begin
      if (m == '0) begin
        price_calc = '0;
      end else if (n > 16'sd48 || shl[98:48] != '0) begin
        price_calc = PRICE_MAX;
        sat_calc   = 1'b1;
      end else begin
        price_calc = shl[47:0];
      end
    end else if (amt >= 16'd64) begin
      price_calc = '0;
    end else if (shr[50:48] != '0) begin
      price_calc = PRICE_MAX;
      sat_calc   = 1'b1;
    end else begin
      price_calc = shr[47:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_TG;
      S_TG:    state_next = S_TGW;
      S_TGW:   state_next = S_SQRT;
      S_SQRT:  if (sqrt_done) state_next = S_SS;
      S_SS:    state_next = S_VOL;
      S_VOL:   state_next = S_E;
      S_E:     state_next = S_DIV;
      S_DIV:   state_next = S_QUO;
      S_QUO:   state_next = S_REM;
      S_REM:   state_next = S_EXPA;
      S_EXPA:  state_next = S_EXPB;
      S_EXPB:  state_next = S_EXPC;
      S_EXPC:  state_next = (idx == 4'(EXP_TERMS)) ? S_PA : S_EXPA;
      S_PA:    state_next = S_PB;
      S_PB:    state_next = S_PC;
      S_PC:    state_next = S_SHIFT;
      S_SHIFT: state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mul_a          = '0;
    mul_b          = '0;
    sqrt_start     = 1'b0;
    variates.ready = 1'b0;
    case (state)
      S_IDLE: begin
        variates.ready = 1'b1;
        sqrt_start     = variates.valid;
      end
      S_TG: begin
        mul_a = 34'(theta);
        mul_b = $signed({2'b00, g});
      end
      S_SS: begin
        mul_a = $signed({3'b000, sigma});
        mul_b = $signed({2'b00, root});
      end
      S_VOL: begin
        mul_a = $signed({3'b000, prod[62:32]});
        mul_b = 34'(z);
      end
      S_DIV: begin
        mul_a = $signed({4'd0, dvd[41:12]});
        mul_b = $signed({17'd0, LN2_RECIP});
      end
      S_QUO: begin
        mul_a = $signed({19'd0, prod[32 +: QUO_W]});
        mul_b = $signed({6'd0, LN2_Q28});
      end
      S_EXPA: begin
        mul_a = $signed({5'd0, term});
        mul_b = $signed({6'd0, r});
      end
      S_EXPB: begin
        mul_a = $signed({6'd0, prod[55:28]});
        mul_b = $signed({1'b0, recip(idx)});
      end
      S_PA: begin
        mul_a = $signed({10'd0, current_price[47:24]});
        mul_b = $signed({4'd0, sum});
      end
      S_PB: begin
        mul_a = $signed({10'd0, current_price[23:0]});
        mul_b = $signed({4'd0, sum});
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_price    <= PRICE_RESET;
      theta          <= '0;
      sigma          <= '0;
      drift_per_step <= '0;
      steps_per_path <= 16'd252;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_START_PRICE: start_price    <= cfg_wdata;
        REG_THETA:       theta          <= $signed(cfg_wdata[31:0]);
        REG_SIGMA:       sigma          <= cfg_wdata[30:0];
        REG_DRIFT:       drift_per_step <= $signed(cfg_wdata[31:0]);
        REG_STEPS:       steps_per_path <= cfg_wdata[15:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_price <= PRICE_RESET;
      step_count    <= '0;
    end else if (accept) begin
      step_count <= cnt_new;
      if (restart) begin
        current_price <= start_price;
      end
    end else if (state == S_SHIFT) begin
      current_price <= price_calc;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          g        <= variates.gamma_variate;
          z        <= variates.normal_variate;
          res_step <= cnt_new_ext[15:0];
          res_last <= (cnt_new_ext == steps_ext);
        end
      end
      S_TGW: tg      <= $signed(prod[63:24]);
      S_E:   dvd     <= dvd_sum;
      S_QUO: quo_est <= prod[32 +: QUO_W];
      S_REM: begin
        r    <= div_rem;
        n    <= $signed({1'b0, quo}) - $signed(QUO_BIAS);
        term <= ONE_Q28;
        sum  <= 30'(ONE_Q28);
        idx  <= 4'd1;
      end
      S_EXPC: begin
        term <= term_new;
        sum  <= sum + 30'(term_new);
        idx  <= idx + 4'd1;
      end
      S_PB: pa <= prod[53:0];
      S_PC: m  <= 51'(pa[53:4]) + 51'(low_sum[54:28]);
      S_SHIFT: begin
        res_price <= price_calc;
        res_sat   <= sat_calc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      results.price        <= res_price;
      results.step_number  <= res_step;
      results.last_of_path <= res_last;
      results.saturated    <= res_sat;
    end
  end

  // A new request is never taken in the cycle right after one was accepted.
  assert property (@(posedge clk) disable iff (rst)
    (variates.valid && variates.ready) |=> !variates.ready)
    else $error("request accepted while a step was in progress");

  assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.saturated) |-> results.price == PRICE_MAX)
    else $error("saturated result without a clamped price");

  assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.last_of_path) |-> results.step_number == steps_per_path)
    else $error("last step marked at the wrong step number");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_REM) |-> div_rem < LN2_Q28)
    else $error("ln2 remainder out of range");

  // The biased exponent is consumed only after it has been latched.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && $past(state) == S_E) |-> dvd == $past(dvd_sum))
    else $error("exponent register does not hold the summed exponent");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the variance gamma price stepper
// A directed table covers reset values, field extremes, saturation, a price
// stuck at zero, zero and short path lengths and ignored register writes.
// Random phases with changing settings follow. Every result is checked against
// the table value if given, else a bit-exact fixed-point path price predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import vgps_pkg::*;

  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 150;

  typedef struct packed {
    logic [47:0] price;
    logic [15:0] step_number;
    logic        last_of_path;
    logic        saturated;
  } step_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [2:0]   addr;
    logic [47:0]  data;
    logic [31:0]  gamma;
    logic [31:0]  normal;
    logic         restart;
    logic         typed;
    step_result_t want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [47:0] cfg_wdata;

  vgps_in_if  vin ();
  vgps_out_if vout ();

  variance_gamma_price_step i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .variates (vin),
    .results  (vout)
  );

  // Mirror of the configuration and path state.
  logic        [47:0] cfg_start;
  logic signed [31:0] cfg_theta;
  logic        [30:0] cfg_sigma;
  logic signed [31:0] cfg_drift;
  logic        [15:0] cfg_steps;
  logic        [47:0] path_price;
  logic        [15:0] path_steps;

  step_result_t expected_prices[$];
  plan_row_t    plan[$];
  int           errors;
  bit           hold_req;
  int           burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic step_result_t advance_path(input logic [31:0] g,
                                                input logic [31:0] z,
                                                input logic restart);
    longint unsigned rad, root, bitv, ss, er, term, hi, lo, a, b, m, px;
    longint          tg, vol, e, n, rem, ln2;
    logic            sat;
    step_result_t    r;
    ln2 = longint'(LN2_Q28);
    if (restart || path_steps >= cfg_steps) begin
      path_price = cfg_start;
      path_steps = '0;
    end
    path_steps = path_steps + 16'd1;

    // Bit-serial integer square root of g * 2^32.
    rad  = {g, 32'd0};
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rad) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rad >= root + bitv) begin
        rad  = rad - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end

    tg  = (longint'(cfg_theta) * longint'(g)) >>> 24;
    ss  = (64'(cfg_sigma) * root) >> 32;
    vol = (longint'(ss) * longint'($signed(z))) >>> 24;
    e   = longint'(cfg_drift) + tg + vol;

    n   = e / ln2;
    rem = e % ln2;
    if (rem < 0) begin
      rem = rem + ln2;
      n   = n - 1;
    end

    er   = 64'(ONE_Q28);
    term = 64'(ONE_Q28);
    for (int i = 1; i <= EXP_TERMS; i++) begin
      term = ((term * longint'(rem)) >> 28) / i;
      er   = er + term;
    end

    hi = path_price >> 24;
    lo = path_price & 64'hFF_FFFF;
    a  = hi * er;
    b  = lo * er;
    m  = (a >> 4) + ((((a & 64'd15) << 24) + b) >> 28);

    sat = 1'b0;
    if (n > 0) begin
      if (m == 0) begin
        px = 0;
      end else if (n > 48 || (m >> (48 - n)) != 0) begin
        sat = 1'b1;
        px  = 64'(PRICE_MAX);
      end else begin
        px = m << n;
      end
    end else if (n < 0) begin
      px = (n <= -64) ? 64'd0 : (m >> (-n));
    end else begin
      px = m;
    end
    if (px > 64'(PRICE_MAX)) begin
      sat = 1'b1;
      px  = 64'(PRICE_MAX);
    end
    path_price = px[47:0];

    r.price        = px[47:0];
    r.step_number  = path_steps;
    r.last_of_path = (path_steps == cfg_steps);
    r.saturated    = sat;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [2:0] addr, input logic [47:0] data);
    plan_row_t p;
    p      = '{kind: ROW_CFG, default: '0};
    p.kind = ROW_CFG;
    p.addr = addr;
    p.data = data;
    return p;
  endfunction

  function automatic plan_row_t item_row(input logic [31:0] g, input logic [31:0] z,
                                         input logic restart, input logic typed,
                                         input logic [47:0] price, input logic [15:0] stepn,
                                         input logic last, input logic sat);
    plan_row_t p;
    p         = '{kind: ROW_ITEM, default: '0};
    p.kind    = ROW_ITEM;
    p.gamma   = g;
    p.normal  = z;
    p.restart = restart;
    p.typed   = typed;
    p.want    = '{price, stepn, last, sat};
    return p;
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // Lets the block drain before a register write.
  task automatic wait_idle();
    vin.valid <= 1'b0;
    while (expected_prices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [47:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_START_PRICE: cfg_start = data;
      REG_THETA:       cfg_theta = data[31:0];
      REG_SIGMA:       cfg_sigma = data[30:0];
      REG_DRIFT:       cfg_drift = data[31:0];
      REG_STEPS:       cfg_steps = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offers one request, waits for acceptance, then maybe leaves a gap.
  task automatic send_step(input logic [31:0] g, input logic [31:0] z, input logic restart,
                           input logic typed, input step_result_t want);
    step_result_t got;
    int gap;
    vin.valid          <= 1'b1;
    vin.gamma_variate  <= g;
    vin.normal_variate <= z;
    vin.new_path       <= restart;
    do @(posedge clk); while (!vin.ready);
    got = advance_path(g, z, restart);
    expected_prices.push_back(typed ? want : got);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        vin.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [31:0] pick_gamma();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return 32'd0;
      default: return $urandom_range(0, 32'h0200_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_normal();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    step_result_t w;
    if (!rst && vout.valid && vout.ready) begin
      if (expected_prices.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        w = expected_prices.pop_front();
        if (vout.price !== w.price)
          report($sformatf("price %h, want %h", vout.price, w.price));
        if (vout.step_number !== w.step_number)
          report($sformatf("step_number %0d, want %0d", vout.step_number, w.step_number));
        if (vout.last_of_path !== w.last_of_path)
          report($sformatf("last_of_path %b, want %b", vout.last_of_path, w.last_of_path));
        if (vout.saturated !== w.saturated)
          report($sformatf("saturated %b, want %b", vout.saturated, w.saturated));
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    int mode;
    int mode_left;
    vout.ready = 1'b0;
    mode_left  = 0;
    mode       = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        vout.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        0:       vout.ready <= 1'b1;
        1:       vout.ready <= 1'($urandom_range(0, 1));
        default: vout.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    plan_row_t    row;
    step_result_t none;
    int           path_pos;
    logic         restart;
    errors             = 0;
    hold_req           = 1'b0;
    burst_left         = 0;
    none               = '0;
    cfg_we             = 1'b0;
    cfg_addr           = '0;
    cfg_wdata          = '0;
    vin.valid          = 1'b0;
    vin.gamma_variate  = '0;
    vin.normal_variate = '0;
    vin.new_path       = 1'b0;
    cfg_start  = PRICE_RESET;
    cfg_theta  = '0;
    cfg_sigma  = '0;
    cfg_drift  = '0;
    cfg_steps  = 16'd252;
    path_price = PRICE_RESET;
    path_steps = '0;

    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With all rates zero the price holds still.
    plan.push_back(item_row(32'd0, 32'd0, 1'b0, 1'b1, PRICE_RESET, 16'd1, 1'b0, 1'b0));
    plan.push_back(item_row(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, PRICE_RESET, 16'd1,
                            1'b0, 1'b0));
    plan.push_back(item_row(32'd1, 32'h8000_0000, 1'b0, 1'b1, PRICE_RESET, 16'd2, 1'b0, 1'b0));
    // A path that has run its length restarts by itself.
    plan.push_back(cfg_row(REG_STEPS, 48'd2));
    plan.push_back(item_row(32'd5, 32'd7, 1'b0, 1'b1, PRICE_RESET, 16'd1, 1'b0, 1'b0));
    plan.push_back(item_row(32'd5, 32'd7, 1'b0, 1'b1, PRICE_RESET, 16'd2, 1'b1, 1'b0));
    // Largest price and drift: the price clamps and stays clamped.
    plan.push_back(cfg_row(REG_START_PRICE, PRICE_MAX));
    plan.push_back(cfg_row(REG_DRIFT, 48'h7FFF_FFFF));
    plan.push_back(item_row(32'd0, 32'd0, 1'b1, 1'b1, PRICE_MAX, 16'd1, 1'b0, 1'b1));
    plan.push_back(item_row(32'd0, 32'd0, 1'b0, 1'b1, PRICE_MAX, 16'd2, 1'b1, 1'b1));
    plan.push_back(cfg_row(REG_DRIFT, 48'hABCD_8000_0000));
    plan.push_back(item_row(32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    // A zero price stays at zero.
    plan.push_back(cfg_row(REG_START_PRICE, 48'd0));
    plan.push_back(item_row(32'd0, 32'd0, 1'b1, 1'b1, 48'd0, 16'd1, 1'b0, 1'b0));
    plan.push_back(item_row(32'd0, 32'd0, 1'b0, 1'b1, 48'd0, 16'd2, 1'b1, 1'b0));
    // Zero path length: every step restarts and none is the last.
    plan.push_back(cfg_row(REG_STEPS, 48'd0));
    plan.push_back(item_row(32'd3, 32'd3, 1'b0, 1'b1, 48'd0, 16'd1, 1'b0, 1'b0));
    plan.push_back(item_row(32'd3, 32'd3, 1'b0, 1'b1, 48'd0, 16'd1, 1'b0, 1'b0));
    // Writes to unused indexes change nothing.
    plan.push_back(cfg_row(REG_SPARE_LO, 48'hFFFF_FFFF_FFFF));
    plan.push_back(cfg_row(REG_SPARE_HI, 48'hFFFF_FFFF_FFFF));
    plan.push_back(item_row(32'd9, 32'd9, 1'b0, 1'b1, 48'd0, 16'd1, 1'b0, 1'b0));
    // Largest theta and sigma with extreme variates.
    plan.push_back(cfg_row(REG_START_PRICE, PRICE_RESET));
    plan.push_back(cfg_row(REG_THETA, 48'h7FFF_FFFF));
    plan.push_back(cfg_row(REG_SIGMA, 48'hFFFF_FFFF_FFFF));
    plan.push_back(cfg_row(REG_DRIFT, 48'd0));
    plan.push_back(cfg_row(REG_STEPS, 48'd65535));
    plan.push_back(item_row(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    plan.push_back(item_row(32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    plan.push_back(item_row(32'h0100_0000, 32'h1000_0000, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    plan.push_back(item_row(32'd0, 32'd0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));

    foreach (plan[k]) begin
      row = plan[k];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.addr, row.data);
      end else begin
        send_step(row.gamma, row.normal, row.restart, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      if (ph == 3) write_reg(REG_START_PRICE, PRICE_MAX - 48'd5);
      else if (ph == 5) write_reg(REG_START_PRICE, 48'({$urandom, $urandom}));
      else write_reg(REG_START_PRICE, 48'($urandom_range(1, 1000)) << 24);
      if (ph == 5) begin
        write_reg(REG_THETA, {16'hFFFF, 32'($urandom)});
        write_reg(REG_SIGMA, {16'h0, 32'($urandom)});
        write_reg(REG_DRIFT, {16'h0, 32'($urandom)});
      end else begin
        write_reg(REG_THETA, 48'($signed(32'($urandom_range(0, 32'h0800_0000))
                                         - 32'h0400_0000)));
        write_reg(REG_SIGMA, 48'($urandom_range(0, 32'h2000_0000)));
        write_reg(REG_DRIFT, 48'($signed(32'($urandom_range(0, 32'h0040_0000))
                                         - 32'h0020_0000)));
      end
      case (ph)
        0:       write_reg(REG_STEPS, 48'd1);
        1:       write_reg(REG_STEPS, 48'd0);
        2:       write_reg(REG_STEPS, 48'd65535);
        default: write_reg(REG_STEPS, 48'($urandom_range(2, 30)));
      endcase
      if (ph == 2) hold_req = 1'b1;
      path_pos = 0;
      for (int k = 0; k < 62; k++) begin
        // Mostly whole paths, with an occasional early restart.
        restart = (path_pos == 0) || ($urandom_range(0, 40) == 0);
        if (restart) path_pos = 0;
        path_pos++;
        if (path_pos >= cfg_steps) path_pos = 0;
        send_step(pick_gamma(), pick_normal(), restart, 1'b0, none);
      end
    end

    vin.valid <= 1'b0;
    while (expected_prices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
